/* sv/crcm_pkg.sv */
// Shared types and constants for the copy-on-write chunk remap table.
// No dependencies; used by the interfaces, the slot cell and the top level.
package crcm_pkg;

	localparam int SECTOR_W     = 48;
	localparam int CHUNK_W      = 45;
	localparam int ID_W         = 16;
	localparam int LEN_W        = 16;
	localparam int COW_W        = 21;
	localparam int OFFSET_W     = 20;
	localparam int COUNT_W      = 32;
	localparam int STATUS_W     = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int SECTOR_BYTES = 512;
	localparam int SECTOR_SHIFT = 9;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SNAP = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COW_BYTES = 2'd2;

	localparam logic [ID_W-1:0] SNAP_ID_RESET = 16'd1;

	// search token control bits, passed cell to cell
	typedef struct packed {
		logic active;
		logic found;
		logic free;
	} tok_flags_t;

endpackage

/* sv/crcm_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on crcm_pkg for field widths.
interface crcm_req_if
	import crcm_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [ID_W-1:0]     target_id;
	logic [SECTOR_W-1:0] sector;
	logic [LEN_W-1:0]    length;

	modport source (output valid, req_type, target_id, sector, length, input ready);
	modport sink (input valid, req_type, target_id, sector, length, output ready);
endinterface

interface crcm_rsp_if
	import crcm_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                hit;
	logic [OFFSET_W-1:0] cow_offset;
	logic                in_range;
	logic [LEN_W-1:0]    done_length;
	logic [COUNT_W-1:0]  write_count;

	modport source (output valid, status, hit, cow_offset, in_range, done_length, write_count,
		input ready);
	modport sink (input valid, status, hit, cow_offset, in_range, done_length, write_count,
		output ready);
endinterface

/* sv/crcm_div.sv */
// Quotient and remainder of a dividend by a fixed power-of-two divisor, by shift and mask.
// No package dependency; used by the top level to split the sector number.
module crcm_div #(
	parameter int W       = 48,
	parameter int DIVISOR = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [W-1:0]                      dividend,
	output logic [W-1:0]                      quot,
	output logic [$clog2(DIVISOR+1):0]        rem
);

	localparam int RW = $clog2(DIVISOR + 1) + 1;
	localparam int SH = $clog2(DIVISOR);

	logic [W-1:0]  quot_q;
	logic [RW-1:0] rem_q;

	// result is ready the cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
			rem_q  <= '0;
		end else if (start) begin
			quot_q <= dividend >> SH;
			rem_q  <= RW'(dividend & W'(DIVISOR - 1));
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

/* sv/crcm_cell.sv */
// One slot of the remap table: valid bit, stored chunk and one stage of the
// search token that walks the chain. Depends on crcm_pkg.
module crcm_cell
	import crcm_pkg::*;
#(
	parameter int MAX_SLOTS = 256,
	parameter int IDX       = 0
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]               n,
	input  tok_flags_t                                   prev_flags,
	input  logic [CHUNK_W-1:0]                           prev_chunk,
	input  logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1)-1:0] prev_found_idx,
	input  logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1)-1:0] prev_free_idx,
	output tok_flags_t                                   nxt_flags,
	output logic [CHUNK_W-1:0]                           nxt_chunk,
	output logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1)-1:0] nxt_found_idx,
	output logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1)-1:0] nxt_free_idx,
	input  logic                                         wr_en,
	input  logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1)-1:0] wr_idx,
	input  logic [CHUNK_W-1:0]                           wr_chunk
);

	localparam int IW = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
	localparam int NW = $clog2(MAX_SLOTS + 1);
	localparam logic [IW-1:0] OWN = IW'(IDX);

	logic               valid_q;
	logic [CHUNK_W-1:0] chunk_q;
	tok_flags_t         flags_q;
	logic [CHUNK_W-1:0] tchunk_q;
	logic [IW-1:0]      found_idx_q;
	logic [IW-1:0]      free_idx_q;
	logic               in_use;
	logic               hit_here;
	logic               free_here;

	always_comb begin
		in_use    = NW'(IDX) < n;
		hit_here  = in_use && valid_q && (chunk_q == prev_chunk);
		free_here = in_use && !valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flags_q <= '0;
		end else begin
			flags_q.active <= prev_flags.active;
			flags_q.found  <= prev_flags.found | hit_here;
			flags_q.free   <= prev_flags.free | free_here;
			if (wr_en && wr_idx == OWN) begin
				valid_q <= 1'b1;
			end
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		tchunk_q    <= prev_chunk;
		found_idx_q <= (!prev_flags.found && hit_here) ? OWN : prev_found_idx;
		free_idx_q  <= (!prev_flags.free && free_here) ? OWN : prev_free_idx;
		if (wr_en && wr_idx == OWN) begin
			chunk_q <= wr_chunk;
		end
	end

	assign nxt_flags     = flags_q;
	assign nxt_chunk     = tchunk_q;
	assign nxt_found_idx = found_idx_q;
	assign nxt_free_idx  = free_idx_q;

endmodule

/* sv/cow_chunk_remap_table_top.sv */
// Copy-on-write snapshot chunk remap table, top level.
// Depends on crcm_pkg, crcm_if, crcm_div and crcm_cell.
//
// Maps each request's CHUNK_BYTES chunk onto a slot of the copy-on-write store.
// Slots live in a row of MAX_SLOTS cells; a search token enters the first cell
// and moves one cell per cycle, picking up the first matching slot and the first
// free slot among the slots in use (cow_bytes / CHUNK_BYTES, capped at
// MAX_SLOTS). A read hit returns the store offset; a read miss means origin.
// A write reuses a matching slot, else claims the first free one, else reports
// store full. One request is worked at a time. A request for a wrong or
// disabled snapshot goes straight to the result register. Any other request
// goes through the split stage (sector to chunk and sector-in-chunk by shift
// and mask), the token walk down the cell chain, the token pick-up, the
// offset step and the result register load, in that order. The next request
// is accepted once the result register is loaded. The result sits in an
// output register, so the next request is accepted while it waits; only a
// second result finding the register still full stalls the block. Slot
// valid bits clear at reset; no clearing pass is needed.
// Configuration must be written only while no request is in flight.
module cow_chunk_remap_table_top
	import crcm_pkg::*;
#(
	parameter int MAX_SLOTS   = 256,
	parameter int CHUNK_BYTES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	crcm_req_if.sink             req,
	crcm_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COW_W-1:0]     cfg_data
);

	localparam int IW    = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
	localparam int NW    = $clog2(MAX_SLOTS + 1);
	localparam int SPC   = CHUNK_BYTES / SECTOR_BYTES;
	localparam int WR_W  = $clog2(SPC + 1) + 1;
	localparam int OFF_W = $clog2(MAX_SLOTS) + $clog2(CHUNK_BYTES) + 1;
	localparam int CMP_W = (OFF_W > COW_W ? OFF_W : COW_W) + 1;
	localparam int CSH   = $clog2(CHUNK_BYTES);

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_WALK, S_OFF, S_RES} state_t;

	state_t state_q;

	// configuration registers
	logic             enabled_q;
	logic [ID_W-1:0]  snap_q;
	logic [COW_W-1:0] cow_q;

	// request context
	logic               is_wr_q;
	logic [LEN_W-1:0]   len_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [WR_W-1:0]    within_q;
	logic [NW-1:0]      n_q;
	logic               head_go_q;
	logic [STATUS_W-1:0] status_q;
	logic               hit_q;
	logic               map_q;
	logic [IW-1:0]      sel_q;
	logic [OFF_W-1:0]   offset_q;
	logic [COUNT_W-1:0] writes_q;

	// slot write bus
	logic               wr_en_q;
	logic [IW-1:0]      wr_idx_q;

	// result register
	logic                out_vld_q;
	logic [STATUS_W-1:0] o_status_q;
	logic                o_hit_q;
	logic [OFFSET_W-1:0] o_offset_q;
	logic                o_rng_q;
	logic [LEN_W-1:0]    o_len_q;
	logic [COUNT_W-1:0]  o_count_q;

	// sector split and slot count
	logic                accept;
	logic [SECTOR_W-1:0] sec_quot;
	logic [WR_W-1:0]     sec_rem;
	logic [COW_W-1:0]    cow_quot;
	logic [NW-1:0]       n_next;

	// cell chain taps
	tok_flags_t         flags  [MAX_SLOTS+1];
	logic [CHUNK_W-1:0] tchunk [MAX_SLOTS+1];
	logic [IW-1:0]      fidx   [MAX_SLOTS+1];
	logic [IW-1:0]      ridx   [MAX_SLOTS+1];

	logic [CMP_W-1:0]   end_byte;
	logic               rng;
	logic [COUNT_W-1:0] count_next;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	crcm_div #(.W(SECTOR_W), .DIVISOR(SPC)) u_sec_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_IDLE && accept && enabled_q && req.target_id == snap_q),
		.dividend (req.sector),
		.quot     (sec_quot),
		.rem      (sec_rem)
	);

	// slots in use, from the current store size
	assign cow_quot = cow_q >> CSH;
	assign n_next   = (cow_quot >= COW_W'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(cow_quot);

	// head of the chain: a fresh token with nothing found yet
	assign flags[0]  = '{active: head_go_q, found: 1'b0, free: 1'b0};
	assign tchunk[0] = chunk_q;
	assign fidx[0]   = '0;
	assign ridx[0]   = '0;

	for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
		crcm_cell #(.MAX_SLOTS(MAX_SLOTS), .IDX(g)) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.n              (n_q),
			.prev_flags     (flags[g]),
			.prev_chunk     (tchunk[g]),
			.prev_found_idx (fidx[g]),
			.prev_free_idx  (ridx[g]),
			.nxt_flags      (flags[g+1]),
			.nxt_chunk      (tchunk[g+1]),
			.nxt_found_idx  (fidx[g+1]),
			.nxt_free_idx   (ridx[g+1]),
			.wr_en          (wr_en_q),
			.wr_idx         (wr_idx_q),
			.wr_chunk       (chunk_q)
		);
	end

	// offset + length against the store size
	always_comb begin
		end_byte   = CMP_W'(offset_q) + CMP_W'(len_q);
		rng        = map_q && (status_q == ST_OK) && (end_byte <= CMP_W'(cow_q));
		count_next = writes_q + COUNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			enabled_q <= 1'b0;
			snap_q    <= SNAP_ID_RESET;
			cow_q     <= '0;
			head_go_q <= 1'b0;
			wr_en_q   <= 1'b0;
			out_vld_q <= 1'b0;
			writes_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLED:   enabled_q <= cfg_data[0];
					CFG_SNAPSHOT:  snap_q    <= cfg_data[ID_W-1:0];
					CFG_COW_BYTES: cow_q     <= cfg_data;
					default: ;
				endcase
			end

			// token launch for one cycle after the split stage
			head_go_q <= (state_q == S_DIV);
			// claim a free slot when a write misses
			wr_en_q   <= (state_q == S_WALK) && flags[MAX_SLOTS].active &&
				!flags[MAX_SLOTS].found && is_wr_q && flags[MAX_SLOTS].free;
			// in S_RES the result register is reloaded on a transfer instead
			if (rsp.valid && rsp.ready && state_q != S_RES) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						is_wr_q  <= (req.req_type == REQ_WRITE);
						len_q    <= req.length;
						hit_q    <= 1'b0;
						map_q    <= 1'b0;
						offset_q <= '0;
						if (!enabled_q || req.target_id != snap_q) begin
							status_q <= ST_NO_SNAP;
							state_q  <= S_RES;
						end else begin
							status_q <= ST_OK;
							state_q  <= S_DIV;
						end
					end
				end
				S_DIV: begin
					chunk_q  <= CHUNK_W'(sec_quot);
					within_q <= sec_rem;
					n_q      <= n_next;
					state_q  <= S_WALK;
				end
				S_WALK: begin
					// token leaves the last cell with the first match and first free slot
					if (flags[MAX_SLOTS].active) begin
						hit_q <= flags[MAX_SLOTS].found;
						if (flags[MAX_SLOTS].found) begin
							map_q <= 1'b1;
							sel_q <= fidx[MAX_SLOTS];
						end else if (is_wr_q && flags[MAX_SLOTS].free) begin
							map_q    <= 1'b1;
							sel_q    <= ridx[MAX_SLOTS];
							wr_idx_q <= ridx[MAX_SLOTS];
						end else if (is_wr_q) begin
							status_q <= ST_FULL;
						end
						state_q <= S_OFF;
					end
				end
				S_OFF: begin
					offset_q <= map_q
						? OFF_W'(sel_q) * OFF_W'(CHUNK_BYTES) + (OFF_W'(within_q) << SECTOR_SHIFT)
						: '0;
					state_q <= S_RES;
				end
				S_RES: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q  <= 1'b1;
						o_status_q <= status_q;
						o_hit_q    <= hit_q;
						o_offset_q <= OFFSET_W'(offset_q);
						o_rng_q    <= rng;
						o_len_q    <= (status_q == ST_OK) ? len_q : '0;
						if (status_q == ST_OK && is_wr_q) begin
							writes_q  <= count_next;
							o_count_q <= count_next;
						end else begin
							o_count_q <= writes_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = o_status_q;
	assign rsp.hit         = o_hit_q;
	assign rsp.cow_offset  = o_offset_q;
	assign rsp.in_range    = o_rng_q;
	assign rsp.done_length = o_len_q;
	assign rsp.write_count = o_count_q;

endmodule
